// ===== hw/rtl/uep0_pkg.sv =====
// ----------------------------------------------------------------------------
// uep0_pkg: shared types and constants of the control endpoint sequencer
// phase codes, transfer end codes, buffer size and result layout
// ----------------------------------------------------------------------------
package uep0_pkg;

	localparam int unsigned BUFFER_BYTES = 256;
	localparam logic [6:0] PKT_MIN = 7'd8;
	localparam logic [6:0] PKT_MAX = 7'd64;
	localparam logic [6:0] PKT_RESET = 7'd64;
	localparam logic [9:0] SETUP_BYTES = 10'd8;

	// event codes
	localparam logic [1:0] FUNC_SETUP = 2'd0;
	localparam logic [1:0] FUNC_IN_SENT = 2'd1;
	localparam logic [1:0] FUNC_OUT_RCVD = 2'd2;
	localparam logic [1:0] FUNC_STALL_SENT = 2'd3;

	// phase codes as reported on the result
	localparam logic [2:0] PH_CODE_IDLE = 3'd0;
	localparam logic [2:0] PH_CODE_IN_DATA = 3'd1;
	localparam logic [2:0] PH_CODE_IN_STATUS = 3'd2;
	localparam logic [2:0] PH_CODE_OUT_DATA = 3'd3;
	localparam logic [2:0] PH_CODE_OUT_STATUS = 3'd4;
	localparam logic [2:0] PH_CODE_STALL = 3'd5;

	// transfer end codes
	localparam logic [2:0] END_NONE = 3'd0;
	localparam logic [2:0] END_OUT_DONE = 3'd1;
	localparam logic [2:0] END_OUT_SHORT = 3'd2;
	localparam logic [2:0] END_IN_DONE = 3'd3;
	localparam logic [2:0] END_IN_SHORT = 3'd4;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_IN_DATA = 6'b000010,
		PH_IN_STATUS = 6'b000100,
		PH_OUT_DATA = 6'b001000,
		PH_OUT_STATUS = 6'b010000,
		PH_STALL = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       set_dir_in;
		logic       tx_ready;
		logic [8:0] tx_offset;
		logic [6:0] tx_count;
		logic       rx_accept;
		logic [8:0] rx_offset;
		logic       rx_overflow;
		logic       force_stall;
		logic [2:0] transfer_end;
		logic [2:0] phase;
	} result_t;

	typedef struct packed {
		logic       tx_ready;
		logic [8:0] tx_offset;
		logic [6:0] tx_count;
		logic [8:0] offset_nxt;
		logic       more;
	} chunk_t;

endpackage

// ===== hw/rtl/usb_ep0_control_transfer_fsm_core.sv =====
// ----------------------------------------------------------------------------
// usb_ep0_control_transfer_fsm_core: control endpoint transfer sequencer
// tracks the control transfer phase and emits one action item per event
// ----------------------------------------------------------------------------
// Takes one event item per clock while in_stall is low (setup, in sent,
// out received, stall sent) and returns exactly one result item for it.
// An event is captured in an input register, evaluated against the phase,
// transfer size and byte offset by a single compare-and-add pass, and
// the result lands in an output register that drives out_valid; the
// sustained rate is one item per cycle while out_stall is low. in_stall
// only rises while both registers are full and the output is stalled. The
// packet size register is written through the cfg port (always ready) and is
// clamped to 8..64 bytes when used; write it only while no event is in
// flight. In replies are cut into packet-size chunks, ending with a short or
// zero-length packet; out chunks are placed at rx_offset or flagged as
// overflow. A setup in a non-idle phase closes the pending request first and
// reports how it ended on transfer_end.
module usb_ep0_control_transfer_fsm_core (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [9:0]  byte_count,
	input  logic        dir_in,
	input  logic [15:0] request_length,
	input  logic        request_handled,
	input  logic [15:0] reply_length,
	input  logic        out_pending,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        set_dir_in,
	output logic        tx_ready,
	output logic [8:0]  tx_offset,
	output logic [6:0]  tx_count,
	output logic        rx_accept,
	output logic [8:0]  rx_offset,
	output logic        rx_overflow,
	output logic        force_stall,
	output logic [2:0]  transfer_end,
	output logic [2:0]  phase,
	// packet size register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	import uep0_pkg::*;

	// input register
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [9:0]  bc_s1;
	logic        dir_s1;
	logic [15:0] rlen_s1;
	logic        handled_s1;
	logic [15:0] reply_s1;
	logic        pend_s1;

	// result register
	logic    valid_s2;
	result_t res_s2;

	// sequencer state
	phase_t     phase_q;
	logic [8:0] size_q;
	logic [8:0] offset_q;
	logic [6:0] pkt_q;

	// next state and result
	phase_t     phase_nxt;
	logic [8:0] size_nxt;
	logic [8:0] offset_nxt;
	result_t    res;

	logic       advance;
	logic [6:0] pkt_eff;
	logic [8:0] setup_size;
	logic [8:0] in_size;
	logic [8:0] chunk_size;
	logic [8:0] chunk_base;
	chunk_t     chunk;
	logic [2:0] end_code;
	logic [10:0] rx_sum;
	logic       rx_fits;
	logic [8:0] rx_offset_new;
	logic [9:0] rx_next_end;

	// --- helpers ---

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] c;
		case (ph)
			PH_IDLE:       c = PH_CODE_IDLE;
			PH_IN_DATA:    c = PH_CODE_IN_DATA;
			PH_IN_STATUS:  c = PH_CODE_IN_STATUS;
			PH_OUT_DATA:   c = PH_CODE_OUT_DATA;
			PH_OUT_STATUS: c = PH_CODE_OUT_STATUS;
			default:       c = PH_CODE_STALL;
		endcase
		return c;
	endfunction

	// arm the next in chunk from a given size and offset
	function automatic chunk_t next_chunk(input logic [8:0] sz, input logic [8:0] base,
			input logic [6:0] ps, input logic pend);
		chunk_t     c;
		logic [8:0] left;
		logic [6:0] n;
		c = '0;
		c.offset_nxt = base;
		left = sz - base;
		n = (left < {2'b00, ps}) ? left[6:0] : ps;
		if (pend) begin
			c.more = 1'b0;
		end else if (sz <= base) begin
			c.tx_ready = 1'b1;
		end else begin
			c.tx_ready = 1'b1;
			c.tx_offset = base;
			c.tx_count = n;
			c.offset_nxt = base + {2'b00, n};
			c.more = (n == ps);
		end
		return c;
	endfunction

	// --- handshake ---

	// result register moves when empty or being taken
	assign advance = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// --- combinational evaluation of the registered event ---

	// packet size clamped into the legal range
	always_comb begin
		if (pkt_q < PKT_MIN) begin
			pkt_eff = PKT_MIN;
		end else if (pkt_q > PKT_MAX) begin
			pkt_eff = PKT_MAX;
		end else begin
			pkt_eff = pkt_q;
		end
	end

	// transfer size from the setup request, capped by buffer and reply
	assign setup_size = (rlen_s1 < 16'(BUFFER_BYTES)) ? rlen_s1[8:0] : 9'(BUFFER_BYTES);
	assign in_size = (reply_s1 < {7'd0, setup_size}) ? reply_s1[8:0] : setup_size;

	// a setup restarts the chunking at offset zero with the new size
	assign chunk_size = (func_s1 == FUNC_SETUP) ? in_size : size_q;
	assign chunk_base = (func_s1 == FUNC_SETUP) ? 9'd0 : offset_q;
	assign chunk = next_chunk(chunk_size, chunk_base, pkt_eff, pend_s1);

	// how the pending request ends when it is closed now
	always_comb begin
		end_code = END_NONE;
		if (phase_q == PH_OUT_STATUS) begin
			end_code = (size_q == offset_q) ? END_OUT_DONE : END_OUT_SHORT;
		end else if (phase_q == PH_IN_STATUS) begin
			end_code = (size_q == offset_q) ? END_IN_DONE : END_IN_SHORT;
		end
	end

	// out data placement and end-of-stage test
	assign rx_sum = {2'b00, offset_q} + {1'b0, bc_s1};
	assign rx_fits = (rx_sum <= {2'b00, size_q});
	assign rx_offset_new = rx_fits ? rx_sum[8:0] : offset_q;
	assign rx_next_end = {1'b0, rx_offset_new} + {3'b000, pkt_eff};

	always_comb begin
		phase_nxt = phase_q;
		size_nxt = size_q;
		offset_nxt = offset_q;
		res = '0;
		case (func_s1)
			FUNC_SETUP: begin
				if (phase_q != PH_IDLE) begin
					res.transfer_end = end_code;
					phase_nxt = PH_IDLE;
				end
				if (bc_s1 != SETUP_BYTES) begin
					// malformed setup
					phase_nxt = PH_STALL;
					res.force_stall = 1'b1;
				end else if (dir_s1) begin
					size_nxt = in_size;
					if (handled_s1) begin
						res.set_dir_in = 1'b1;
						res.tx_ready = chunk.tx_ready;
						res.tx_offset = chunk.tx_offset;
						res.tx_count = chunk.tx_count;
						offset_nxt = chunk.offset_nxt;
						phase_nxt = chunk.more ? PH_IN_DATA : PH_IN_STATUS;
					end else begin
						// request not handled
						phase_nxt = PH_STALL;
						res.force_stall = 1'b1;
					end
				end else begin
					size_nxt = setup_size;
					offset_nxt = 9'd0;
					if (rlen_s1 == 16'd0) begin
						// no data stage, arm the status packet
						res.tx_ready = 1'b1;
						phase_nxt = PH_OUT_STATUS;
					end else begin
						phase_nxt = PH_OUT_DATA;
					end
				end
			end
			FUNC_IN_SENT: begin
				case (phase_q)
					PH_IDLE, PH_IN_STATUS: begin
						phase_nxt = phase_q;
					end
					PH_OUT_STATUS: begin
						res.transfer_end = end_code;
						phase_nxt = PH_IDLE;
					end
					PH_IN_DATA: begin
						res.tx_ready = chunk.tx_ready;
						res.tx_offset = chunk.tx_offset;
						res.tx_count = chunk.tx_count;
						offset_nxt = chunk.offset_nxt;
						phase_nxt = chunk.more ? PH_IN_DATA : PH_IN_STATUS;
					end
					default: begin
						phase_nxt = PH_STALL;
						res.force_stall = 1'b1;
					end
				endcase
			end
			FUNC_OUT_RCVD: begin
				case (phase_q)
					PH_IDLE: begin
						phase_nxt = phase_q;
					end
					PH_IN_STATUS, PH_IN_DATA: begin
						res.transfer_end = end_code;
						phase_nxt = PH_IDLE;
					end
					PH_OUT_DATA: begin
						if (rx_fits) begin
							res.rx_accept = 1'b1;
							res.rx_offset = offset_q;
						end else begin
							res.rx_overflow = 1'b1;
						end
						offset_nxt = rx_offset_new;
						// a full packet with room for another keeps the data stage open
						if (!(bc_s1 == {3'b000, pkt_eff} && rx_next_end <= {1'b0, size_q}))
								begin
							phase_nxt = PH_OUT_STATUS;
							res.tx_ready = 1'b1;
						end
					end
					default: begin
						phase_nxt = PH_STALL;
						res.force_stall = 1'b1;
					end
				endcase
			end
			default: begin
				// stall sent: no effect
				phase_nxt = phase_q;
			end
		endcase
		res.phase = phase_code(phase_nxt);
	end

	// --- registers ---

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			bc_s1 <= byte_count;
			dir_s1 <= dir_in;
			rlen_s1 <= request_length;
			handled_s1 <= request_handled;
			reply_s1 <= reply_length;
			pend_s1 <= out_pending;
		end
	end

	// sequencer state, updated as an item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			size_q <= 9'd0;
			offset_q <= 9'd0;
		end else if (valid_s1 && advance) begin
			phase_q <= phase_nxt;
			size_q <= size_nxt;
			offset_q <= offset_nxt;
		end
	end

	// packet size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= PKT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pkt_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res;
		end
	end

	// --- outputs ---

	assign out_valid = valid_s2;
	assign set_dir_in = res_s2.set_dir_in;
	assign tx_ready = res_s2.tx_ready;
	assign tx_offset = res_s2.tx_offset;
	assign tx_count = res_s2.tx_count;
	assign rx_accept = res_s2.rx_accept;
	assign rx_offset = res_s2.rx_offset;
	assign rx_overflow = res_s2.rx_overflow;
	assign force_stall = res_s2.force_stall;
	assign transfer_end = res_s2.transfer_end;
	assign phase = res_s2.phase;

endmodule
